// File: rtl/tcptx_pkg.sv
// ----------------------------------------------------------------------------
// tcptx_pkg
// Shared types, constants and ring arithmetic for the transmit window tracker.
// ----------------------------------------------------------------------------
package tcptx_pkg;

   localparam int WINDOW_SIZE  = 4096;
   localparam int SOCKET_COUNT = 16;

   localparam int KIND_W   = 3;
   localparam int SOCK_W   = 4;
   localparam int CNT_W    = 13;
   localparam int OFF_W    = 12;
   localparam int OCC_W    = CNT_W + 1;
   localparam int REQ_DW   = 24;
   localparam int RSP_DW   = 104;

   typedef enum logic [KIND_W-1:0] {
      KIND_QUERY  = 3'd0,
      KIND_APPEND = 3'd1,
      KIND_SENT   = 3'd2,
      KIND_ACKED  = 3'd3,
      KIND_REWIND = 3'd4
   } kind_type;

   // per-socket ring state, one memory word
   typedef struct packed {
      logic [OFF_W-1:0] free_off;
      logic [OFF_W-1:0] send_off;
      logic [OFF_W-1:0] unacked_off;
      logic [CNT_W-1:0] send_cnt;
      logic [CNT_W-1:0] unacked_cnt;
   } entry_type;

   typedef struct packed {
      logic             overrun;
      logic [CNT_W-1:0] free_total;
      logic [CNT_W-1:0] free_linear;
      logic [CNT_W-1:0] send_total;
      logic [CNT_W-1:0] send_linear;
      logic [CNT_W-1:0] unacked_total;
      logic [OFF_W-1:0] free_at;
      logic [OFF_W-1:0] send_at;
      logic [OFF_W-1:0] unacked_at;
   } result_type;

   // advance a ring offset, wrapping once at the window end
   function automatic logic [OFF_W-1:0] ring_advance(input logic [OFF_W-1:0] at,
                                                     input logic [CNT_W-1:0] len);
      logic [OCC_W-1:0] sum;
      sum = OCC_W'(at) + OCC_W'(len);
      if (sum < OCC_W'(WINDOW_SIZE)) begin
         return OFF_W'(sum);
      end
      return OFF_W'(sum - OCC_W'(WINDOW_SIZE));
   endfunction

endpackage

// File: rtl/tcptx_state_mem.sv
// ----------------------------------------------------------------------------
// tcptx_state_mem
// Per-socket state memory, registered read, valid bit per entry.
// ----------------------------------------------------------------------------
module tcptx_state_mem #(
   parameter int DEPTH = tcptx_pkg::SOCKET_COUNT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output tcptx_pkg::entry_type  rd_data,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  tcptx_pkg::entry_type  wr_data
);

   tcptx_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   tcptx_pkg::entry_type rd_data_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entries never written read as the reset value (all zero)
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: rtl/tcptx_update.sv
// ----------------------------------------------------------------------------
// tcptx_update
// Applies one request to a socket entry and forms the reported lengths.
// ----------------------------------------------------------------------------
module tcptx_update (
   input  logic [tcptx_pkg::KIND_W-1:0] kind,
   input  logic [tcptx_pkg::CNT_W-1:0]  length,
   input  logic                         in_range,
   input  tcptx_pkg::entry_type         cur,
   output tcptx_pkg::entry_type         nxt,
   output logic                         wr_en,
   output tcptx_pkg::result_type        res
);

   localparam int CNT_W = tcptx_pkg::CNT_W;
   localparam int OCC_W = tcptx_pkg::OCC_W;
   localparam logic [OCC_W-1:0] WIN = OCC_W'(tcptx_pkg::WINDOW_SIZE);

   logic [OCC_W-1:0] occ_cur;
   logic [CNT_W-1:0] free_cur;
   logic [OCC_W-1:0] occ_nxt;
   logic [CNT_W-1:0] free_nxt;
   logic [CNT_W-1:0] free_lin;
   logic [CNT_W-1:0] send_lin;
   logic             over;

   assign occ_cur  = OCC_W'(cur.send_cnt) + OCC_W'(cur.unacked_cnt);
   assign free_cur = (occ_cur <= WIN) ? CNT_W'(WIN - occ_cur) : '0;

   always_comb begin
      nxt  = cur;
      over = 1'b0;
      case (kind)
         tcptx_pkg::KIND_APPEND: begin
            if (length > free_cur) begin
               over = 1'b1;
            end else begin
               nxt.free_off = tcptx_pkg::ring_advance(cur.free_off, length);
               nxt.send_cnt = cur.send_cnt + length;
            end
         end
         tcptx_pkg::KIND_SENT: begin
            if (length > cur.send_cnt) begin
               over = 1'b1;
            end else begin
               nxt.send_off    = tcptx_pkg::ring_advance(cur.send_off, length);
               nxt.send_cnt    = cur.send_cnt - length;
               nxt.unacked_cnt = cur.unacked_cnt + length;
            end
         end
         tcptx_pkg::KIND_ACKED: begin
            if (length > cur.unacked_cnt) begin
               over = 1'b1;
            end else begin
               nxt.unacked_off = tcptx_pkg::ring_advance(cur.unacked_off, length);
               nxt.unacked_cnt = cur.unacked_cnt - length;
            end
         end
         tcptx_pkg::KIND_REWIND: begin
            if (occ_cur > WIN) begin
               over = 1'b1;
            end else begin
               nxt.send_off    = cur.unacked_off;
               nxt.send_cnt    = CNT_W'(occ_cur);
               nxt.unacked_cnt = '0;
            end
         end
         default: begin
            // query and unused kinds
         end
      endcase
   end

   assign occ_nxt  = OCC_W'(nxt.send_cnt) + OCC_W'(nxt.unacked_cnt);
   assign free_nxt = (occ_nxt <= WIN) ? CNT_W'(WIN - occ_nxt) : '0;

   always_comb begin
      free_lin = '0;
      if (free_nxt != '0) begin
         if (nxt.unacked_off > nxt.free_off) begin
            free_lin = free_nxt;
         end else if (OCC_W'(nxt.free_off) < WIN) begin
            free_lin = CNT_W'(WIN - OCC_W'(nxt.free_off));
         end
      end
      send_lin = '0;
      if (nxt.send_cnt != '0) begin
         if (nxt.free_off > nxt.send_off) begin
            send_lin = nxt.send_cnt;
         end else if (nxt.send_cnt >= CNT_W'(nxt.free_off)) begin
            send_lin = nxt.send_cnt - CNT_W'(nxt.free_off);
         end
      end
   end

   assign wr_en = in_range;

   always_comb begin
      if (in_range) begin
         res.overrun       = over;
         res.free_total    = free_nxt;
         res.free_linear   = free_lin;
         res.send_total    = nxt.send_cnt;
         res.send_linear   = send_lin;
         res.unacked_total = nxt.unacked_cnt;
         res.free_at       = nxt.free_off;
         res.send_at       = nxt.send_off;
         res.unacked_at    = nxt.unacked_off;
      end else begin
         res         = '0;
         res.overrun = 1'b1;
      end
   end

endmodule

// File: rtl/tcp_tx_ring_window_tracker.sv
// ----------------------------------------------------------------------------
// tcp_tx_ring_window_tracker
// Per-socket transmit ring pointers and byte counts, one request per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: an operation (req_tuser) on one socket with a
//   byte length. Every request yields exactly one response on rsp_* holding
//   the overrun flag (rsp_tuser), the socket's lengths and its three offsets,
//   all taken after the operation.
//   An accepted request passes the update stage and the output register to rsp_*.
//   Throughput: one request per cycle while rsp_tready is high, including
//   back-to-back requests to the same socket; the state memory is read at
//   accept and written by the update stage, forwarding the last written entry.
//   A refused operation (overrun) leaves the socket state untouched; a socket
//   index at or above SOCKET_COUNT reports overrun with all other fields zero.
//   Reset clears all per-socket state at once through per-entry valid bits;
//   requests are taken in the first cycle after reset.
//   When rsp_tready is low the response holds in the output register, one
//   more request can sit in the update stage, and req_tready then drops.
// ----------------------------------------------------------------------------
module tcp_tx_ring_window_tracker #(
   parameter int SOCKET_COUNT = tcptx_pkg::SOCKET_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [3:0] socket, [16:4] length, [23:17] zero
   input  logic [tcptx_pkg::REQ_DW-1:0]  req_tdata,
   // [2:0] kind
   input  logic [tcptx_pkg::KIND_W-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [12:0] free_total, [25:13] free_linear, [38:26] send_total,
   // [51:39] send_linear, [64:52] unacked_total, [76:65] free_at,
   // [88:77] send_at, [100:89] unacked_at, [103:101] zero
   output logic [tcptx_pkg::RSP_DW-1:0]  rsp_tdata,
   // [0] overrun
   output logic                          rsp_tuser
);

   localparam int IDX_W  = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
   localparam int SOCK_W = tcptx_pkg::SOCK_W;
   localparam int CNT_W  = tcptx_pkg::CNT_W;

   // request fields
   logic [SOCK_W-1:0] req_socket;
   logic [CNT_W-1:0]  req_length;
   logic              req_in_range;
   logic [IDX_W-1:0]  req_idx;
   logic              req_fire;

   assign req_socket   = req_tdata[SOCK_W-1:0];
   assign req_length   = req_tdata[SOCK_W +: CNT_W];
   assign req_in_range = int'(req_socket) < SOCKET_COUNT;
   assign req_idx      = IDX_W'(req_socket);

   // update stage
   logic                        s1_vld_ff;
   logic [IDX_W-1:0]            s1_idx_ff;
   logic [tcptx_pkg::KIND_W-1:0] s1_kind_ff;
   logic [CNT_W-1:0]            s1_len_ff;
   logic                        s1_in_range_ff;
   logic                        s1_adv;

   // forwarding of the most recent write
   logic                        fwd_vld_ff;
   logic [IDX_W-1:0]            fwd_idx_ff;
   tcptx_pkg::entry_type        fwd_ff;

   // output register
   logic                        out_vld_ff;
   tcptx_pkg::result_type       out_ff;

   tcptx_pkg::entry_type        mem_rd;
   tcptx_pkg::entry_type        cur;
   tcptx_pkg::entry_type        nxt;
   tcptx_pkg::result_type       res;
   logic                        upd_wr;
   logic                        mem_wr;

   assign s1_adv     = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign mem_wr     = s1_adv && upd_wr;

   tcptx_state_mem #(
      .DEPTH (SOCKET_COUNT),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (mem_rd),
      .wr_en   (mem_wr),
      .wr_addr (s1_idx_ff),
      .wr_data (nxt)
   );

   // a write landing on the edge of this entry's read is taken from the bypass
   assign cur = (fwd_vld_ff && fwd_idx_ff == s1_idx_ff) ? fwd_ff : mem_rd;

   tcptx_update u_upd (
      .kind     (s1_kind_ff),
      .length   (s1_len_ff),
      .in_range (s1_in_range_ff),
      .cur      (cur),
      .nxt      (nxt),
      .wr_en    (upd_wr),
      .res      (res)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (mem_wr) begin
            fwd_vld_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff      <= req_idx;
         s1_kind_ff     <= req_tuser;
         s1_len_ff      <= req_length;
         s1_in_range_ff <= req_in_range;
      end
      if (mem_wr) begin
         fwd_idx_ff <= s1_idx_ff;
         fwd_ff     <= nxt;
      end
      if (s1_adv) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.overrun;
   assign rsp_tdata  = {3'b000,
                        out_ff.unacked_at, out_ff.send_at, out_ff.free_at,
                        out_ff.unacked_total, out_ff.send_linear, out_ff.send_total,
                        out_ff.free_linear, out_ff.free_total};

endmodule

// File: rtl/tcptx_checker.sv
// ----------------------------------------------------------------------------
// tcptx_checker
// Port-level checks for the transmit window tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tcptx_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tcptx_pkg::RSP_DW-1:0]  rsp_tdata,
   input logic                          rsp_tuser
);

   localparam int CNT_W = tcptx_pkg::CNT_W;
   localparam int OCC_W = tcptx_pkg::OCC_W + 1;

   logic [2:0]       pend_ff;
   logic             req_fire;
   logic             rsp_fire;
   logic [OCC_W-1:0] total_sum;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 3'(req_fire) - 3'(rsp_fire);
      end
   end

   assign total_sum = OCC_W'(rsp_tdata[CNT_W-1:0])
                    + OCC_W'(rsp_tdata[3*CNT_W-1:2*CNT_W])
                    + OCC_W'(rsp_tdata[5*CNT_W-1:4*CNT_W]);

   // every response belongs to an accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 3'd0)
      else $error("response without an outstanding request");

   // never more than two requests in flight
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("more than two requests in flight");

   // free + queued + unacknowledged always fill the window, unless the socket is out of range
   a_window_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (total_sum == OCC_W'(tcptx_pkg::WINDOW_SIZE))
                     || (rsp_tuser && rsp_tdata == '0))
      else $error("window lengths do not add up");

   // contiguous send run never exceeds the queued count
   a_send_lin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4*CNT_W-1:3*CNT_W] <= rsp_tdata[3*CNT_W-1:2*CNT_W])
      else $error("send_linear above send_total");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

bind tcp_tx_ring_window_tracker tcptx_checker u_tcptx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
